[src/bba_pkg.sv]
// Shared types, constants and helpers of the bitmap block allocator.
package bba_pkg;

   localparam int NUM_CHUNKS = 16;
   localparam int MAX_BLOCKS = 64;
   localparam int RAMP_STEPS = 8;

   localparam int MASK_W    = 64;
   localparam int CHUNK_W   = 4;
   localparam int OFF_W     = 6;
   localparam int CNT_W     = 7;
   localparam int TOTAL_W   = 11;
   localparam int OPEN_W    = $clog2(NUM_CHUNKS + 1);
   localparam int STEP_W    = $clog2(RAMP_STEPS + 1);
   localparam int PROD_W    = STEP_W + CNT_W;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_MIN_NEW  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_NEW = 2'd1;

   typedef enum logic [1:0] {
      OP_ALLOC = 2'd0,
      OP_GROW  = 2'd1,
      OP_FREE  = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_NOFIT = 2'd1,
      STAT_FULL  = 2'd2,
      STAT_BAD   = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_TAKE,
      S_OPEN,
      S_MODIFY
   } state_type;

   typedef struct packed {
      op_type             op;
      logic [CHUNK_W-1:0] chunk_index;
      logic [OFF_W-1:0]   run_offset;
      logic [CNT_W-1:0]   run_blocks;
      logic [CNT_W-1:0]   extra_blocks;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [CHUNK_W-1:0] granted_chunk;
      logic [OFF_W-1:0]   granted_offset;
      logic [CNT_W-1:0]   granted_blocks;
      logic               opened_chunk;
      logic [CNT_W-1:0]   opened_chunk_blocks;
      logic [TOTAL_W-1:0] total_blocks;
   } rsp_type;

   typedef struct packed {
      logic               en;
      logic [CHUNK_W-1:0] addr;
      logic [MASK_W-1:0]  data;
   } mask_wr_type;

   typedef struct packed {
      logic             hit;
      logic [OFF_W-1:0] offset;
   } find_type;

   function automatic logic [MASK_W-1:0] low_ones(input logic [CNT_W-1:0] n);
      logic [MASK_W-1:0] r;
      if (n >= CNT_W'(MASK_W)) begin
         r = '1;
      end else begin
         r = ~({MASK_W{1'b1}} << n);
      end
      return r;
   endfunction

   function automatic logic [CNT_W-1:0] sat_max(input logic [CNT_W-1:0] v);
      return (v > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : v;
   endfunction

endpackage

[src/bba_mask_store.sv]
// Free-mask memory, one 64-bit word per chunk, registered read.
module bba_mask_store (
   input  logic                        clock,
   input  bba_pkg::mask_wr_type        wr,
   input  logic [bba_pkg::CHUNK_W-1:0] rd_addr,
   output logic [bba_pkg::MASK_W-1:0]  rd_data
);
   import bba_pkg::*;

   logic [MASK_W-1:0] mem [NUM_CHUNKS];
   logic [MASK_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[src/bba_run_finder.sv]
// First-fit finder: lowest offset of a run of free blocks in one mask.
module bba_run_finder (
   input  logic [bba_pkg::MASK_W-1:0] mask,
   input  logic [bba_pkg::CNT_W-1:0]  count,
   output bba_pkg::find_type          find
);
   import bba_pkg::*;

   logic [MASK_W:0]   pow [CNT_W];
   logic [MASK_W:0]   acc [CNT_W+1];
   logic [MASK_W-1:0] win;

   always_comb begin
      pow[0] = {1'b0, mask};
      for (int b = 1; b < CNT_W; b++) begin
         pow[b] = pow[b-1] & (pow[b-1] >> (1 << (b - 1)));
      end
      acc[0] = '1;
      for (int b = 0; b < CNT_W; b++) begin
         acc[b+1] = count[b] ? ((acc[b] >> (1 << b)) & pow[b]) : acc[b];
      end
      win = acc[CNT_W][MASK_W-1:0];
   end

   always_comb begin
      find.hit    = |win;
      find.offset = '0;
      for (int i = MASK_W - 1; i >= 0; i--) begin
         if (win[i]) begin
            find.offset = OFF_W'(i);
         end
      end
   end

endmodule

[src/bitmap_block_allocator.sv]
// Bitmap first-fit block allocator: sequencer, registers and result word.
// A rejected request is answered straight from idle; grow and free pass through modify;
// allocate scans open chunks, then takes the run found, opens a chunk or reports full.
// Allocate checks one chunk mask per cycle through the single run finder.
// Busy stays high until the result strobe; the next request is taken then.
// Reset clears chunk count and block total and loads config defaults; masks load on open.
module bitmap_block_allocator (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  bba_pkg::req_type              req_word,
   output logic                          rsp_valid,
   output bba_pkg::rsp_type              rsp_word,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [bba_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bba_pkg::CNT_W-1:0]     csr_wdata
);
   import bba_pkg::*;

   state_type          state_ff, state_in;
   req_type            req_ff, req_in;
   logic [CHUNK_W-1:0] scan_ff, scan_in;
   logic [OFF_W-1:0]   hit_off_ff, hit_off_in;
   logic [MASK_W-1:0]  mask_ff, mask_in;
   logic [OPEN_W-1:0]  chunks_ff, chunks_in;
   logic [TOTAL_W-1:0] blocks_ff, blocks_in;
   logic [CNT_W-1:0]   min_ff, base_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   mask_wr_type        mwr;
   logic [CHUNK_W-1:0] rd_addr;
   logic [MASK_W-1:0]  rd_data;
   find_type           find;

   logic               alloc_ok, held_ok;
   logic [CNT_W-1:0]   base_sat, min_sat, ramp, size;
   logic [STEP_W-1:0]  steps;
   logic [PROD_W-1:0]  prod;
   logic [CNT_W:0]     end_pos;
   logic [CNT_W+1:0]   grow_end;
   logic [MASK_W-1:0]  want, held;
   logic [CHUNK_W-1:0] scan_nxt;

   bba_mask_store u_store (
      .clock   (clock),
      .wr      (mwr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   bba_run_finder u_finder (
      .mask  (rd_data),
      .count (req_ff.run_blocks),
      .find  (find)
   );

   always_comb begin
      alloc_ok = (req_word.run_blocks != '0) && (req_word.run_blocks <= CNT_W'(MAX_BLOCKS));
      held_ok  = (OPEN_W'(req_word.chunk_index) < chunks_ff)
               && (req_word.run_blocks != '0)
               && ((CNT_W+1)'(req_word.run_offset) + (CNT_W+1)'(req_word.run_blocks)
                   <= (CNT_W+1)'(MASK_W));
   end

   always_comb begin
      base_sat = sat_max(base_ff);
      min_sat  = sat_max(min_ff);
      steps    = (int'(chunks_ff) < RAMP_STEPS) ? STEP_W'(chunks_ff) : STEP_W'(RAMP_STEPS);
      prod     = PROD_W'(steps) * PROD_W'(CNT_W'(MAX_BLOCKS) - base_sat);
      ramp     = base_sat + CNT_W'(prod / RAMP_STEPS);
      size     = min_sat;
      if (ramp > size) begin
         size = ramp;
      end
      if (req_ff.run_blocks > size) begin
         size = req_ff.run_blocks;
      end
      size = sat_max(size);
   end

   always_comb begin
      end_pos  = (CNT_W+1)'(req_ff.run_offset) + (CNT_W+1)'(req_ff.run_blocks);
      grow_end = (CNT_W+2)'(end_pos) + (CNT_W+2)'(req_ff.extra_blocks);
      want     = low_ones(req_ff.extra_blocks) << end_pos;
      held     = low_ones(req_ff.run_blocks) << req_ff.run_offset;
      scan_nxt = scan_ff + CHUNK_W'(1);
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      scan_in      = scan_ff;
      hit_off_in   = hit_off_ff;
      mask_in      = mask_ff;
      chunks_in    = chunks_ff;
      blocks_in    = blocks_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      rd_addr      = scan_ff;
      mwr          = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in = req_word;
               rsp_in = '0;
               unique case (req_word.op)
                  OP_ALLOC: begin
                     if (!alloc_ok) begin
                        rsp_in.status = STAT_BAD;
                        rsp_valid_in  = 1'b1;
                     end else if (chunks_ff == '0) begin
                        state_in = S_OPEN;
                     end else begin
                        scan_in  = '0;
                        rd_addr  = '0;
                        state_in = S_SCAN;
                     end
                  end
                  OP_GROW, OP_FREE: begin
                     if (held_ok) begin
                        rd_addr  = req_word.chunk_index;
                        state_in = S_MODIFY;
                     end else begin
                        rsp_in.status = STAT_BAD;
                        rsp_valid_in  = 1'b1;
                     end
                  end
                  default: begin
                     rsp_in.status = STAT_BAD;
                     rsp_valid_in  = 1'b1;
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (find.hit) begin
               hit_off_in = find.offset;
               mask_in    = rd_data;
               state_in   = S_TAKE;
            end else if (OPEN_W'(scan_ff) + OPEN_W'(1) == chunks_ff) begin
               if (chunks_ff == OPEN_W'(NUM_CHUNKS)) begin
                  rsp_in        = '0;
                  rsp_in.status = STAT_FULL;
                  rsp_valid_in  = 1'b1;
                  state_in      = S_IDLE;
               end else begin
                  state_in = S_OPEN;
               end
            end else begin
               scan_in = scan_nxt;
               rd_addr = scan_nxt;
            end
         end
         S_TAKE: begin
            mwr.en                = 1'b1;
            mwr.addr              = scan_ff;
            mwr.data              = mask_ff & ~(low_ones(req_ff.run_blocks) << hit_off_ff);
            rsp_in                = '0;
            rsp_in.status         = STAT_OK;
            rsp_in.granted_chunk  = scan_ff;
            rsp_in.granted_offset = hit_off_ff;
            rsp_in.granted_blocks = req_ff.run_blocks;
            rsp_valid_in          = 1'b1;
            state_in              = S_IDLE;
         end
         S_OPEN: begin
            mwr.en                     = 1'b1;
            mwr.addr                   = chunks_ff[CHUNK_W-1:0];
            mwr.data                   = low_ones(size) & ~low_ones(req_ff.run_blocks);
            chunks_in                  = chunks_ff + OPEN_W'(1);
            blocks_in                  = blocks_ff + TOTAL_W'(size);
            rsp_in                     = '0;
            rsp_in.status              = STAT_OK;
            rsp_in.granted_chunk       = chunks_ff[CHUNK_W-1:0];
            rsp_in.granted_blocks      = req_ff.run_blocks;
            rsp_in.opened_chunk        = 1'b1;
            rsp_in.opened_chunk_blocks = size;
            rsp_valid_in               = 1'b1;
            state_in                   = S_IDLE;
         end
         S_MODIFY: begin
            rsp_in                = '0;
            rsp_in.granted_chunk  = req_ff.chunk_index;
            rsp_in.granted_offset = req_ff.run_offset;
            rsp_in.status         = STAT_OK;
            mwr.addr              = req_ff.chunk_index;
            if (req_ff.op == OP_FREE) begin
               mwr.en   = 1'b1;
               mwr.data = rd_data | held;
            end else if (req_ff.extra_blocks == '0) begin
               rsp_in.granted_blocks = req_ff.run_blocks;
            end else if (grow_end > (CNT_W+2)'(MASK_W)) begin
               rsp_in.status         = STAT_NOFIT;
               rsp_in.granted_blocks = req_ff.run_blocks;
            end else if ((rd_data & want) == want) begin
               mwr.en                = 1'b1;
               mwr.data              = rd_data & ~want;
               rsp_in.granted_blocks = req_ff.run_blocks + req_ff.extra_blocks;
            end else begin
               rsp_in.status         = STAT_NOFIT;
               rsp_in.granted_blocks = req_ff.run_blocks;
            end
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_in.total_blocks = blocks_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         chunks_ff    <= '0;
         blocks_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chunks_ff    <= chunks_in;
         blocks_ff    <= blocks_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      scan_ff    <= scan_in;
      hit_off_ff <= hit_off_in;
      mask_ff    <= mask_in;
      rsp_ff     <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff  <= CNT_W'(1);
         base_ff <= CNT_W'(16);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MIN_NEW:  min_ff  <= csr_wdata;
            CSR_BASE_NEW: base_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   a_bad_op_rejects: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_word.op == OP_NONE)
      |=> rsp_valid && (rsp_word.status == STAT_BAD))
      else $error("unknown op not rejected");

   a_chunk_limit: assert property (@(posedge clock) disable iff (reset)
      chunks_ff <= OPEN_W'(NUM_CHUNKS))
      else $error("chunk count past limit");

   a_open_has_room: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OPEN) |-> (chunks_ff < OPEN_W'(NUM_CHUNKS)))
      else $error("open with no chunk left");

   a_open_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.opened_chunk
      |-> (rsp_word.status == STAT_OK)
          && (rsp_word.opened_chunk_blocks >= rsp_word.granted_blocks))
      else $error("opened chunk result inconsistent");

endmodule
